>>> hdl/smx_pkg.sv
// shared types, constants and level mapping for the stereo mixer register file
package smx_pkg;

  // mixer geometry and volume limits
  localparam int unsigned CHANNEL_COUNT  = 6;
  localparam int unsigned VOLUME_MAX     = 100;
  localparam int unsigned VOLUME_DEFAULT = 75;
  // channels 0 to 4 own a codec register
  localparam int unsigned CODEC_CHANNELS = 5;

  localparam int unsigned ChanW   = 3;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned VolW    = 7;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CodecW  = 5;

  // v*31/100 as v * (31 * ceil(2^19/100)) >> 19, exact for v below 128
  localparam int unsigned CodecShift = 19;
  localparam int unsigned CodecMul   = 31 * 5243;
  localparam int unsigned ProdW      = 25;
  localparam int unsigned ScaledW    = ProdW - CodecShift;

  // access kinds
  typedef enum logic [2:0] {
    KIND_SET_VOLUME   = 3'd0,
    KIND_SET_MUTE     = 3'd1,
    KIND_WRITE_PACKED = 3'd2,
    KIND_READ_PACKED  = 3'd3,
    KIND_WRITE_REC    = 3'd4,
    KIND_READ_REC     = 3'd5
  } kind_e;

  // one access, last field in the lowest bits
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic              mute_request;
    logic [LevelW-1:0] right_level;
    logic [LevelW-1:0] left_level;
    logic [ChanW-1:0]  channel;
  } req_t;

  // one result, last field in the lowest bits
  typedef struct packed {
    logic              codec_mute;
    logic [CodecW-1:0] codec_right;
    logic [CodecW-1:0] codec_left;
    logic [ChanW-1:0]  codec_slot;
    logic              codec_update;
    logic              error;
    logic [WordW-1:0]  read_data;
  } res_t;

  localparam int unsigned ReqW   = $bits(req_t);
  localparam int unsigned InDataW  = ((ReqW + 7) / 8) * 8;
  localparam int unsigned ResW   = $bits(res_t);
  localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8;

  // clamp a requested level to the volume maximum
  function automatic logic [VolW-1:0] clamp_level(input logic [LevelW-1:0] lvl);
    logic [VolW-1:0] res;
    if (lvl > LevelW'(VOLUME_MAX)) res = VolW'(VOLUME_MAX);
    else res = lvl[VolW-1:0];
    return res;
  endfunction

  // inverted codec attenuation, saturated at zero
  function automatic logic [CodecW-1:0] codec_level(input logic [VolW-1:0] vol);
    logic [ProdW-1:0]   prod;
    logic [ScaledW-1:0] scaled;
    logic [CodecW-1:0]  res;
    prod   = ProdW'(vol) * ProdW'(CodecMul);
    scaled = prod[ProdW-1:CodecShift];
    if (scaled > ScaledW'(31)) res = '0;
    else res = CodecW'(ScaledW'(31) - scaled);
    return res;
  endfunction

endpackage

>>> hdl/smx_chan_regs.sv
// per-channel volume, mute and record-select state with access decode
module smx_chan_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [2:0]    kind_i,
  input  smx_pkg::req_t req_i,
  input  logic          codec_present_i,
  output smx_pkg::res_t res_o
);
  import smx_pkg::*;

  logic [VolW-1:0] left_q [CHANNEL_COUNT];
  logic [VolW-1:0] right_q [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] mute_q;
  logic [CHANNEL_COUNT-1:0] rec_q;

  logic [VolW-1:0] left_d, right_d;
  logic            mute_d;
  logic            chan_wr;
  logic            rec_wr;
  logic            ch_valid;
  logic            changed;
  logic [ChanW-1:0] ch;
  logic [VolW-1:0] cur_left, cur_right;
  logic            cur_mute;

  assign ch       = req_i.channel;
  assign ch_valid = ch < ChanW'(CHANNEL_COUNT);
  assign cur_left  = ch_valid ? left_q[ch]  : '0;
  assign cur_right = ch_valid ? right_q[ch] : '0;
  assign cur_mute  = ch_valid ? mute_q[ch]  : 1'b0;

  // decode the access and build the result
  always_comb begin
    left_d  = cur_left;
    right_d = cur_right;
    mute_d  = cur_mute;
    chan_wr = 1'b0;
    rec_wr  = 1'b0;
    changed = 1'b0;
    res_o   = '0;
    unique case (kind_e'(kind_i)) inside
      KIND_SET_VOLUME, KIND_SET_MUTE, KIND_WRITE_PACKED, KIND_READ_PACKED: begin
        if (!ch_valid) begin
          res_o.error = 1'b1;
        end else begin
          unique case (kind_e'(kind_i))
            KIND_SET_VOLUME: begin
              left_d  = clamp_level(req_i.left_level);
              right_d = clamp_level(req_i.right_level);
              changed = 1'b1;
            end
            KIND_SET_MUTE: begin
              mute_d  = req_i.mute_request;
              changed = 1'b1;
            end
            KIND_WRITE_PACKED: begin
              left_d  = clamp_level(req_i.word[7:0]);
              right_d = clamp_level({1'b0, req_i.word[14:8]});
              mute_d  = req_i.word[15];
              changed = 1'b1;
            end
            default: begin
              res_o.read_data = {cur_mute, cur_right, 1'b0, cur_left};
            end
          endcase
          chan_wr = changed;
        end
      end
      KIND_WRITE_REC: begin
        rec_wr = 1'b1;
      end
      KIND_READ_REC: begin
        res_o.read_data = WordW'(rec_q);
      end
      default: begin
      end
    endcase
    // level update toward the codec
    if (changed && codec_present_i && ch < ChanW'(CODEC_CHANNELS)) begin
      res_o.codec_update = 1'b1;
      res_o.codec_slot   = ch;
      res_o.codec_left   = codec_level(left_d);
      res_o.codec_right  = codec_level(right_d);
      res_o.codec_mute   = mute_d;
    end
  end

  // state update when the access completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        left_q[i]  <= VolW'(VOLUME_DEFAULT);
        right_q[i] <= VolW'(VOLUME_DEFAULT);
      end
      mute_q <= '0;
      rec_q  <= '0;
    end else if (en_i) begin
      if (chan_wr) begin
        left_q[ch]  <= left_d;
        right_q[ch] <= right_d;
        mute_q[ch]  <= mute_d;
      end
      if (rec_wr) begin
        rec_q <= req_i.word[CHANNEL_COUNT-1:0];
      end
    end
  end

endmodule

>>> hdl/stereo_mixer_register_file_core.sv
// top level of the stereo mixer register file with stream ports
// Six-channel stereo mixer register file. Each access word on the slave stream
// (kind in tuser) sets volumes, mute, a packed level word or the record mask,
// or reads them back, and yields exactly one result word on the master stream.
// An access is held in an input register, decoded and applied to the channel
// state, and the result lands in an output register; one word per cycle is
// sustained while the master stream accepts results. With codec_present set,
// volume and mute changes on channels 0 to 4 also report the inverted 5-bit
// codec levels in the result. The user must write the configuration register
// only while no access is in flight; the block itself does not enforce this.
module stereo_mixer_register_file_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: codec_present
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // channel, left_level, right_level, mute_request, word, zero pad
  input  logic [smx_pkg::InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [2:0]                   s_axis_tuser,
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // read_data, error, codec_update, codec_slot, codec_left, codec_right, codec_mute
  output logic [smx_pkg::OutDataW-1:0] m_axis_tdata
);
  import smx_pkg::*;

  logic       codec_present_q;
  logic       in_valid_q;
  req_t       in_req_q;
  logic [2:0] in_kind_q;
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       res;
  logic       advance;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_present_q <= 1'b0;
    end else if (cfg_valid_i) begin
      codec_present_q <= cfg_data_i;
    end
  end

  // pipeline flow
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q  <= s_axis_tdata[ReqW-1:0];
      in_kind_q <= s_axis_tuser;
    end
  end

  // channel state and access decode
  smx_chan_regs u_chan_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .kind_i          (in_kind_q),
    .req_i           (in_req_q),
    .codec_present_i (codec_present_q),
    .res_o           (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_res_q);

endmodule
